@@ hdl/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants, command codes and control types for the timer pool.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int IDX_W       = $clog2(SLOT_COUNT);
    localparam int FIRST_ALLOC = 2;

    localparam logic [15:0] RESET_TICKS = 16'd1002;
    localparam logic [31:0] FREE_MARK   = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_DELAY = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the accepted item, rewind the slot index
        logic step;    // process the slot at the current address
        logic finish;  // update counters and load the result register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic multi;   // command walks the slot file
        logic last;    // index is at the last slot
        logic found;   // start has placed its delay
    } t_dp_status;

endpackage

@@ hdl/ctp_in_if.sv @@
// ----------------------------------------------------------------------------
// ctp_in_if
// Command channel of the timer pool: valid/ready plus the command fields.
// ----------------------------------------------------------------------------
interface ctp_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [5:0]         slot_id;
    logic signed [31:0] delay_value;

    modport source (output valid, command, slot_id, delay_value, input ready);
    modport sink   (input valid, command, slot_id, delay_value, output ready);
endinterface

@@ hdl/ctp_out_if.sv @@
// ----------------------------------------------------------------------------
// ctp_out_if
// Result channel of the timer pool: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface ctp_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         slot;
    logic signed [31:0] slot_value;
    logic [31:0]        seconds_total;
    logic [31:0]        milliseconds_total;

    modport source (output valid, slot, slot_value, seconds_total, milliseconds_total,
                    input ready);
    modport sink   (input valid, slot, slot_value, seconds_total, milliseconds_total,
                    output ready);
endinterface

@@ hdl/ctp_datapath.sv @@
// ----------------------------------------------------------------------------
// ctp_datapath
// Slot register file, tick/second counters, config register and result regs.
// ----------------------------------------------------------------------------
module ctp_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  ctp_pkg::t_ctrl_cmd  i_cmd,
    output ctp_pkg::t_dp_status o_status,
    input  logic [2:0]          i_command,
    input  logic [5:0]          i_slot_id,
    input  logic signed [31:0]  i_delay_value,
    output logic [6:0]          o_slot,
    output logic signed [31:0]  o_slot_value,
    output logic [31:0]         o_seconds_total,
    output logic [31:0]         o_milliseconds_total
);

    logic [31:0]               r_slots [ctp_pkg::SLOT_COUNT];
    logic [15:0]               r_ticks_per_second;
    logic [15:0]               r_countdown;
    logic [31:0]               r_seconds;
    logic [31:0]               r_ticks;

    logic [2:0]                r_op;
    logic [5:0]                r_id;
    logic [31:0]               r_delay;
    logic [ctp_pkg::IDX_W-1:0] r_idx;
    logic                      r_found;
    logic [ctp_pkg::IDX_W-1:0] r_found_idx;

    logic [6:0]                r_res_slot;
    logic [31:0]               r_res_value;
    logic [31:0]               r_res_seconds;
    logic [31:0]               r_res_ticks;

    logic                      walk;
    logic                      id_in_range;
    logic [ctp_pkg::IDX_W-1:0] addr;
    logic [31:0]               rd;
    logic                      wr_en;
    logic [31:0]               wr_data;
    logic                      hit;
    logic [15:0]               n_countdown;
    logic [31:0]               n_seconds;
    logic [31:0]               n_ticks;

    function automatic logic is_positive(input logic [31:0] v);
        return (v != 32'd0) && !v[31];
    endfunction

    assign walk        = (r_op == ctp_pkg::CMD_TICK) || (r_op == ctp_pkg::CMD_START);
    assign id_in_range = {1'b0, r_id} < 7'(ctp_pkg::SLOT_COUNT);

    always_comb begin
        case (r_op)
            ctp_pkg::CMD_TICK, ctp_pkg::CMD_START: addr = r_idx;
            ctp_pkg::CMD_DELAY:                    addr = '0;
            default:                               addr = r_id[ctp_pkg::IDX_W-1:0];
        endcase
    end

    assign rd = r_slots[addr];

    // start takes the lowest free slot from FIRST_ALLOC up
    assign hit = !r_delay[31] && !r_found && (rd == ctp_pkg::FREE_MARK)
               && (r_idx >= ctp_pkg::IDX_W'(ctp_pkg::FIRST_ALLOC));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd;
        case (r_op)
            ctp_pkg::CMD_TICK: begin
                wr_en   = is_positive(rd);
                wr_data = rd - 32'd1;
            end
            ctp_pkg::CMD_START: begin
                wr_en   = hit;
                wr_data = r_delay;
            end
            ctp_pkg::CMD_STOP: begin
                wr_en   = id_in_range && (r_id >= 6'(ctp_pkg::FIRST_ALLOC));
                wr_data = ctp_pkg::FREE_MARK;
            end
            ctp_pkg::CMD_DELAY: begin
                wr_en   = is_positive(r_delay);
                wr_data = r_delay;
            end
            default: begin
                wr_en   = 1'b0;
                wr_data = rd;
            end
        endcase
    end

    always_comb begin
        n_countdown = r_countdown;
        n_seconds   = r_seconds;
        n_ticks     = r_ticks;
        if (r_op == ctp_pkg::CMD_TICK) begin
            if (r_countdown == 16'd0) begin
                n_seconds   = r_seconds + 32'd1;
                n_countdown = r_ticks_per_second;
            end else begin
                n_countdown = r_countdown - 16'd1;
            end
            n_ticks = r_ticks + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ctp_pkg::SLOT_COUNT; i++) begin
                r_slots[i] <= (i < ctp_pkg::FIRST_ALLOC) ? 32'd0 : ctp_pkg::FREE_MARK;
            end
            r_ticks_per_second <= ctp_pkg::RESET_TICKS;
            r_countdown        <= ctp_pkg::RESET_TICKS;
            r_seconds          <= '0;
            r_ticks            <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ticks_per_second <= i_cfg_wdata;
            end
            if (i_cmd.step && wr_en) begin
                r_slots[addr] <= wr_data;
            end
            if (i_cmd.finish) begin
                r_countdown <= n_countdown;
                r_seconds   <= n_seconds;
                r_ticks     <= n_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_command;
            r_id    <= i_slot_id;
            r_delay <= i_delay_value;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + ctp_pkg::IDX_W'(1);
            if ((r_op == ctp_pkg::CMD_START) && hit) begin
                r_found     <= 1'b1;
                r_found_idx <= r_idx;
            end
        end
        if (i_cmd.finish) begin
            if (r_op == ctp_pkg::CMD_START) begin
                r_res_slot <= r_found ? 7'(r_found_idx) : 7'(ctp_pkg::SLOT_COUNT);
            end else begin
                r_res_slot <= '0;
            end
            r_res_value   <= ((r_op == ctp_pkg::CMD_READ) && id_in_range) ? rd : 32'd0;
            r_res_seconds <= n_seconds;
            r_res_ticks   <= n_ticks;
        end
    end

    assign o_status.multi = walk;
    assign o_status.last  = (r_idx == ctp_pkg::IDX_W'(ctp_pkg::SLOT_COUNT - 1));
    assign o_status.found = r_found;

    assign o_slot               = r_res_slot;
    assign o_slot_value         = r_res_value;
    assign o_seconds_total      = r_res_seconds;
    assign o_milliseconds_total = r_res_ticks;

endmodule

@@ hdl/ctp_controller.sv @@
// ----------------------------------------------------------------------------
// ctp_controller
// Sequencer: accepts an item, walks the slot file, hands over the result.
// ----------------------------------------------------------------------------
module ctp_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ctp_pkg::t_ctrl_cmd  o_cmd,
    input  ctp_pkg::t_dp_status i_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                // single-slot commands take one step; start ends once placed
                if (!i_status.multi || i_status.last || i_status.found) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_acc_to_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_WALK))
        else $error("accepted item did not start processing");

    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && i_status.last |=> (r_state == S_DONE))
        else $error("walk ran past the last slot");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

endmodule

@@ hdl/countdown_timer_pool.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_pool
// Pool of countdown slots with millisecond tick and seconds counters.
// ----------------------------------------------------------------------------
// Each item gives one result. A tick walks the slot register file one slot
// per clock, and its result is offered once the walk has done the last
// slot. A start walks the same file from slot 0 and stops on the step after
// placing its delay, or at the last slot when it takes the last slot, finds
// none free or has a negative delay. Stop, read and delay do not walk the
// file; they touch a single slot. One item is processed at a time; the next
// one is taken the cycle after a result is loaded. A new item may be
// accepted while the previous result waits to be taken; its own result is
// then held back until that one has gone.
// ticks_per_second is written through i_cfg_we/i_cfg_wdata and is used at the
// next seconds reload.
module countdown_timer_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ctp_in_if.sink      i_item,
    ctp_out_if.source   o_result
);

    ctp_pkg::t_ctrl_cmd  cmd;
    ctp_pkg::t_dp_status status;

    ctp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    ctp_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_command            (i_item.command),
        .i_slot_id            (i_item.slot_id),
        .i_delay_value        (i_item.delay_value),
        .o_slot               (o_result.slot),
        .o_slot_value         (o_result.slot_value),
        .o_seconds_total      (o_result.seconds_total),
        .o_milliseconds_total (o_result.milliseconds_total)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for countdown_timer_pool. A short directed run hits the
// corner cases of every command. Randomized phases follow, each opening with a
// write of its seconds reload value. Both channels idle at random, but for the
// phases whose idle limit for that side is zero. Every reply is compared field
// by field with an in-bench model of the slot pool and its counters.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;   // cycles with no handshake on either side
    localparam int SETTLE_CYC = 24;     // settle time, longer than the longest command
    localparam int REPORT_MAX = 10;
    localparam int PHASES     = 6;

    typedef struct packed {
        logic [6:0]  slot;
        logic [31:0] slot_value;
        logic [31:0] seconds_total;
        logic [31:0] milliseconds_total;
    } t_reply;

    class t_pool_scoreboard;
        logic [31:0] counters [ctp_pkg::SLOT_COUNT];
        logic [15:0] countdown;
        logic [15:0] reload_ticks;
        logic [31:0] seconds;
        logic [31:0] ticks;
        t_reply      owed_replies [$];
        int          mismatches;
        int          cmd_hits [8];
        int          refused_starts;
        int          reload_writes;

        function new();
            for (int k = 0; k < ctp_pkg::SLOT_COUNT; k++) begin
                counters[k] = (k < ctp_pkg::FIRST_ALLOC) ? 32'd0 : ctp_pkg::FREE_MARK;
            end
            reload_ticks   = ctp_pkg::RESET_TICKS;
            countdown      = ctp_pkg::RESET_TICKS;
            seconds        = '0;
            ticks          = '0;
            mismatches     = 0;
            refused_starts = 0;
            reload_writes  = 0;
            for (int k = 0; k < 8; k++) begin
                cmd_hits[k] = 0;
            end
        endfunction

        function void set_reload(logic [15:0] value);
            reload_ticks = value;
            reload_writes++;
        endfunction

        // Advance the model by one accepted item and queue the reply it owes.
        function void apply_command(logic [2:0] cmd, logic [5:0] id, logic [31:0] dly);
            t_reply reply;
            bit     placed;
            reply  = '0;
            placed = 1'b0;
            cmd_hits[cmd]++;
            case (cmd)
                ctp_pkg::CMD_TICK: begin
                    for (int k = 0; k < ctp_pkg::SLOT_COUNT; k++) begin
                        if (counters[k] != 32'd0 && !counters[k][31])
                            counters[k] = counters[k] - 32'd1;
                    end
                    if (countdown == 16'd0) begin
                        seconds   = seconds + 32'd1;
                        countdown = reload_ticks;
                    end else begin
                        countdown = countdown - 16'd1;
                    end
                    ticks = ticks + 32'd1;
                end
                ctp_pkg::CMD_START: begin
                    reply.slot = 7'(ctp_pkg::SLOT_COUNT);
                    if (!dly[31]) begin
                        for (int k = ctp_pkg::FIRST_ALLOC; k < ctp_pkg::SLOT_COUNT; k++) begin
                            if (!placed && counters[k] == ctp_pkg::FREE_MARK) begin
                                counters[k] = dly;
                                reply.slot  = 7'(k);
                                placed      = 1'b1;
                            end
                        end
                    end
                    if (!placed)
                        refused_starts++;
                end
                ctp_pkg::CMD_STOP: begin
                    if (id >= ctp_pkg::FIRST_ALLOC && id < ctp_pkg::SLOT_COUNT)
                        counters[id] = ctp_pkg::FREE_MARK;
                end
                ctp_pkg::CMD_READ: begin
                    if (id < ctp_pkg::SLOT_COUNT)
                        reply.slot_value = counters[id];
                end
                ctp_pkg::CMD_DELAY: begin
                    if (dly != 32'd0 && !dly[31])
                        counters[0] = dly;
                end
                default: ;
            endcase
            reply.seconds_total      = seconds;
            reply.milliseconds_total = ticks;
            owed_replies.push_back(reply);
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            if (owed_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected reply slot %0d value %0d sec %0d ms %0d",
                             $time, got.slot, $signed(got.slot_value),
                             got.seconds_total, got.milliseconds_total);
                return;
            end
            want = owed_replies.pop_front();
            if (got.slot !== want.slot || got.slot_value !== want.slot_value ||
                got.seconds_total !== want.seconds_total ||
                got.milliseconds_total !== want.milliseconds_total) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: reply mismatch", $time);
                    $display("    expected slot %0d value %0d sec %0d ms %0d",
                             want.slot, $signed(want.slot_value),
                             want.seconds_total, want.milliseconds_total);
                    $display("    actual   slot %0d value %0d sec %0d ms %0d",
                             got.slot, $signed(got.slot_value),
                             got.seconds_total, got.milliseconds_total);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    ctp_in_if  cmd_bus ();
    ctp_out_if reply_bus ();

    countdown_timer_pool u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (cmd_bus),
        .o_result    (reply_bus)
    );

    t_pool_scoreboard board;
    int tx_gap_max   = 10;
    int rx_stall_max = 10;

    // Per phase: reload value, item count, tick share in percent, start-heavy
    // mix so the pool runs full, and the idle limits of both sides.
    // The first seconds reload needs 1003 ticks, hence the tick-heavy start.
    int phase_tps   [PHASES] = '{65535, 3, 0, 1, 0, 65535};
    int phase_items [PHASES] = '{400, 400, 300, 200, 200, 100};
    int phase_ticks [PHASES] = '{95, 90, 85, 50, 40, 60};
    bit phase_fill  [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int phase_txgap [PHASES] = '{10, 0, 10, 10, 3, 10};
    int phase_rxgap [PHASES] = '{10, 10, 0, 10, 10, 0};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [2:0] cmd, input logic [5:0] id,
                             input logic [31:0] dly);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid       = 1'b1;
        cmd_bus.command     = cmd;
        cmd_bus.slot_id     = id;
        cmd_bus.delay_value = dly;
        @(posedge i_clk);
        while (cmd_bus.ready !== 1'b1) @(posedge i_clk);
        board.apply_command(cmd, id, dly);
        @(negedge i_clk);
    endtask

    // Hold off new items until every owed reply has come back.
    task automatic drain_replies();
        cmd_bus.valid = 1'b0;
        while (board.owed_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reload(input logic [15:0] value);
        drain_replies();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_reload(value);
    endtask

    task automatic random_item(input int tick_pct, input bit fill);
        logic [2:0]  cmd;
        logic [5:0]  id;
        logic [31:0] dly;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < tick_pct) begin
            cmd = ctp_pkg::CMD_TICK;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < (fill ? 55 : 30))
                cmd = ctp_pkg::CMD_START;
            else if (roll < (fill ? 65 : 60))
                cmd = ctp_pkg::CMD_STOP;
            else if (roll < 85)
                cmd = ctp_pkg::CMD_READ;
            else if (roll < 95)
                cmd = ctp_pkg::CMD_DELAY;
            else
                cmd = ctp_pkg::CMD_DELAY + 3'($urandom_range(1, 3));
        end
        // mostly slots in range, now and then anywhere in the id space
        if ($urandom_range(0, 4) == 0)
            id = 6'($urandom_range(0, 63));
        else
            id = 6'($urandom_range(0, ctp_pkg::SLOT_COUNT - 1));
        // short delays so slots actually run down to zero under ticks
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dly = $urandom_range(0, 40);
            5:             dly = $urandom_range(41, 3000);
            6:             dly = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:       dly = $urandom;
        endcase
        send_item(cmd, id, dly);
    endtask

    initial begin : stimulus
        board       = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.command     = ctp_pkg::CMD_TICK;
        cmd_bus.slot_id     = '0;
        cmd_bus.delay_value = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reserved slots, a free slot, out-of-range reads
        send_item(ctp_pkg::CMD_READ, 6'd0, 32'd0);
        send_item(ctp_pkg::CMD_READ, 6'd1, 32'd0);
        send_item(ctp_pkg::CMD_READ, 6'd15, 32'd0);
        send_item(ctp_pkg::CMD_READ, 6'd16, 32'd0);
        send_item(ctp_pkg::CMD_READ, 6'd63, 32'hFFFF_FFFF);
        // start: zero delay, largest delay, negative delays refused
        send_item(ctp_pkg::CMD_START, 6'd0, 32'd0);
        send_item(ctp_pkg::CMD_START, 6'd0, 32'h7FFF_FFFF);
        send_item(ctp_pkg::CMD_START, 6'd0, 32'h8000_0000);
        send_item(ctp_pkg::CMD_START, 6'd0, 32'hFFFF_FFFF);
        // delay slot: zero and negative ignored, then largest and one
        send_item(ctp_pkg::CMD_DELAY, 6'd0, 32'd0);
        send_item(ctp_pkg::CMD_DELAY, 6'd0, 32'h8000_0000);
        send_item(ctp_pkg::CMD_DELAY, 6'd0, 32'h7FFF_FFFF);
        send_item(ctp_pkg::CMD_DELAY, 6'd0, 32'd1);
        // slot 0 reaches zero and stays there
        send_item(ctp_pkg::CMD_TICK, 6'd0, 32'd0);
        send_item(ctp_pkg::CMD_TICK, 6'd63, 32'hFFFF_FFFF);
        // stops of reserved and out-of-range slots are ignored; slot 2 is freed and read
        send_item(ctp_pkg::CMD_STOP, 6'd0, 32'd0);
        send_item(ctp_pkg::CMD_STOP, 6'd1, 32'd0);
        send_item(ctp_pkg::CMD_STOP, 6'd63, 32'd0);
        send_item(ctp_pkg::CMD_STOP, 6'd16, 32'd0);
        send_item(ctp_pkg::CMD_STOP, 6'd2, 32'd0);
        send_item(ctp_pkg::CMD_READ, 6'd2, 32'd0);
        // unused codes leave state alone; a start then retakes slot 2
        send_item(ctp_pkg::CMD_DELAY + 3'd1, 6'd63, 32'hFFFF_FFFF);
        send_item(ctp_pkg::CMD_DELAY + 3'd2, 6'd2, 32'd5);
        send_item(ctp_pkg::CMD_DELAY + 3'd3, 6'd0, 32'h8000_0000);
        send_item(ctp_pkg::CMD_START, 6'd0, 32'd5);

        for (int p = 0; p < PHASES; p++) begin
            write_reload(16'(phase_tps[p]));
            tx_gap_max   = phase_txgap[p];
            rx_stall_max = phase_rxgap[p];
            for (int n = 0; n < phase_items[p]; n++) begin
                if (n == phase_items[p] / 2)
                    drain_replies();
                random_item(phase_ticks[p], phase_fill[p]);
            end
        end

        drain_replies();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d ticks, %0d starts (%0d refused), %0d stops, %0d reads,",
                 board.cmd_hits[ctp_pkg::CMD_TICK], board.cmd_hits[ctp_pkg::CMD_START],
                 board.refused_starts,
                 board.cmd_hits[ctp_pkg::CMD_STOP], board.cmd_hits[ctp_pkg::CMD_READ]);
        $display("%0d delay loads, %0d unused codes; %0d seconds over %0d reload writes",
                 board.cmd_hits[ctp_pkg::CMD_DELAY],
                 board.cmd_hits[5] + board.cmd_hits[6] + board.cmd_hits[7],
                 board.seconds, board.reload_writes);
        if (board.mismatches == 0 && board.owed_replies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : reply_sink
        int     stall;
        t_reply got;
        reply_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                reply_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            reply_bus.ready = 1'b1;
            @(posedge i_clk);
            while (reply_bus.valid !== 1'b1) @(posedge i_clk);
            got.slot               = reply_bus.slot;
            got.slot_value         = reply_bus.slot_value;
            got.seconds_total      = reply_bus.seconds_total;
            got.milliseconds_total = reply_bus.milliseconds_total;
            board.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (reply_bus.valid === 1'b1 && reply_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ctp_pkg.sv
hdl/ctp_in_if.sv
hdl/ctp_out_if.sv
hdl/ctp_datapath.sv
hdl/ctp_controller.sv
hdl/countdown_timer_pool.sv
tb/sv/tb_top.sv
